// ===== rtl/core/rbfs_pkg.sv =====
// Shared types and constants for the ray and box face select block.
package rbfs_pkg;

  localparam int WORD_W           = 32;
  localparam int NUM_AXES         = 3;
  localparam int NUM_REGS         = 6;
  localparam int CFG_IDX_W        = 3;
  localparam int FACE_W           = 3;
  localparam int FRAC_BITS_DEF    = 16;
  localparam int PARALLEL_EPS_DEF = 1;

  localparam logic [WORD_W-1:0] BOX_LOW_RST  = 32'h0000_0000;
  localparam logic [WORD_W-1:0] BOX_HIGH_RST = 32'h0001_0000;
  localparam logic [FACE_W-1:0] FACE_NONE    = 3'd0;
  localparam logic [FACE_W-1:0] FACE_MAX     = 3'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_X  = 3'd0,
    REG_LOW_Y  = 3'd1,
    REG_LOW_Z  = 3'd2,
    REG_HIGH_X = 3'd3,
    REG_HIGH_Y = 3'd4,
    REG_HIGH_Z = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic signed [WORD_W-1:0] origin_x;
    logic signed [WORD_W-1:0] origin_y;
    logic signed [WORD_W-1:0] origin_z;
    logic signed [WORD_W-1:0] dir_x;
    logic signed [WORD_W-1:0] dir_y;
    logic signed [WORD_W-1:0] dir_z;
  } ray_t;

  typedef struct packed {
    logic              hit;
    logic [FACE_W-1:0] face;
  } res_t;

  // Per-ray flags that ride alongside the dividers.
  typedef struct packed {
    logic [NUM_AXES-1:0] par;
    logic [NUM_AXES-1:0] neg_lo;
    logic [NUM_AXES-1:0] neg_hi;
    logic                miss;
  } side_t;

endpackage

// ===== rtl/core/rbfs_div.sv =====
// Pipelined unsigned restoring divider, two quotient bits per stage.
module rbfs_div #(
  parameter int FRAC_BITS = rbfs_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [rbfs_pkg::WORD_W-1:0]       num_i,
  input  logic [rbfs_pkg::WORD_W-1:0]       den_i,
  output logic [2*((rbfs_pkg::WORD_W+FRAC_BITS+1)/2)-1:0] quo_o
);
  import rbfs_pkg::*;

  localparam int NumW   = WORD_W + FRAC_BITS;
  localparam int Stages = (NumW + 1) / 2;
  localparam int QuoW   = 2 * Stages;

  logic [WORD_W-1:0] rem_q [Stages];
  logic [QuoW-1:0]   nq_q  [Stages];
  logic [WORD_W-1:0] den_q [Stages];

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic [WORD_W-1:0] rem_in, den_in, rem_d;
    logic [QuoW-1:0]   nq_in, nq_d;
    logic [WORD_W:0]   part;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = QuoW'({num_i, {FRAC_BITS{1'b0}}});
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign nq_in  = nq_q[s-1];
      assign den_in = den_q[s-1];
    end

    // The numerator shifts out at the top while quotient bits shift in below.
    always_comb begin
      rem_d = rem_in;
      nq_d  = nq_in;
      part  = '0;
      for (int b = 0; b < 2; b++) begin
        part = {rem_d, nq_d[QuoW-1]};
        nq_d = {nq_d[QuoW-2:0], 1'b0};
        if (part >= {1'b0, den_in}) begin
          part    = part - {1'b0, den_in};
          nq_d[0] = 1'b1;
        end
        rem_d = part[WORD_W-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d;
        nq_q[s]  <= nq_d;
        den_q[s] <= den_in;
      end
    end
  end

  assign quo_o = nq_q[Stages-1];

endmodule

// ===== rtl/core/ray_box_face_select.sv =====
// Top level of the ray and box face select block.
// Tests one ray per word against the configured axis-aligned box and returns
// whether it hits and which face. One ray is accepted every cycle unless
// in_stall_o is high, which it is while the skid entry holds a result. Six
// restoring dividers, one per slab bound, sit between the prep stage and the
// saturate stage and resolve two quotient bits per stage. An output register
// with a skid entry lets the pipeline keep moving while one result waits.
module ray_box_face_select #(
  parameter int FRAC_BITS    = rbfs_pkg::FRAC_BITS_DEF,
  parameter int PARALLEL_EPS = rbfs_pkg::PARALLEL_EPS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rbfs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rbfs_pkg::WORD_W-1:0]    cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  rbfs_pkg::ray_t                 in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output rbfs_pkg::res_t                 out_data_o
);
  import rbfs_pkg::*;

  localparam int NumW    = WORD_W + FRAC_BITS;
  localparam int DivSt   = (NumW + 1) / 2;
  localparam int QuoW    = 2 * DivSt;
  localparam int FldIdx  = DivSt + 3;
  localparam int TW      = WORD_W + 1;

  // Configuration registers.
  logic [WORD_W-1:0] cfg_q [NUM_REGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[REG_LOW_X]  <= BOX_LOW_RST;
      cfg_q[REG_LOW_Y]  <= BOX_LOW_RST;
      cfg_q[REG_LOW_Z]  <= BOX_LOW_RST;
      cfg_q[REG_HIGH_X] <= BOX_HIGH_RST;
      cfg_q[REG_HIGH_Y] <= BOX_HIGH_RST;
      cfg_q[REG_HIGH_Z] <= BOX_HIGH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LOW_X:  cfg_q[REG_LOW_X]  <= cfg_wdata_i;
        REG_LOW_Y:  cfg_q[REG_LOW_Y]  <= cfg_wdata_i;
        REG_LOW_Z:  cfg_q[REG_LOW_Z]  <= cfg_wdata_i;
        REG_HIGH_X: cfg_q[REG_HIGH_X] <= cfg_wdata_i;
        REG_HIGH_Y: cfg_q[REG_HIGH_Y] <= cfg_wdata_i;
        REG_HIGH_Z: cfg_q[REG_HIGH_Z] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The whole pipeline advances unless the skid entry holds a word.
  logic          adv;
  logic          skid_v_q, out_valid_q;
  logic [FldIdx:0] v_q;

  assign adv        = !skid_v_q;
  assign in_stall_o = skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[FldIdx-1:0], in_valid_i};
    end
  end

  // Prep stage: slab offsets, magnitudes, signs and parallel checks.
  logic [WORD_W-1:0] org [NUM_AXES];
  logic [WORD_W-1:0] dir [NUM_AXES];
  assign org[0] = in_data_i.origin_x;
  assign org[1] = in_data_i.origin_y;
  assign org[2] = in_data_i.origin_z;
  assign dir[0] = in_data_i.dir_x;
  assign dir[1] = in_data_i.dir_y;
  assign dir[2] = in_data_i.dir_z;

  logic [WORD_W-1:0] mag_lo_q [NUM_AXES];
  logic [WORD_W-1:0] mag_hi_q [NUM_AXES];
  logic [WORD_W-1:0] dmag_q   [NUM_AXES];
  side_t             side_d;
  side_t             side_q [DivSt+1];
  logic [NUM_AXES-1:0] outside;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_prep
    logic [TW-1:0]     dlo, dhi, nlo, nhi;
    logic [WORD_W-1:0] dmag;

    assign dlo  = {cfg_q[a][WORD_W-1], cfg_q[a]} - {org[a][WORD_W-1], org[a]};
    assign dhi  = {cfg_q[a+NUM_AXES][WORD_W-1], cfg_q[a+NUM_AXES]}
                - {org[a][WORD_W-1], org[a]};
    assign nlo  = -dlo;
    assign nhi  = -dhi;
    assign dmag = dir[a][WORD_W-1] ? -dir[a] : dir[a];

    assign side_d.par[a]    = dmag < WORD_W'(PARALLEL_EPS);
    assign side_d.neg_lo[a] = dlo[WORD_W] ^ dir[a][WORD_W-1];
    assign side_d.neg_hi[a] = dhi[WORD_W] ^ dir[a][WORD_W-1];
    assign outside[a] = ($signed(org[a]) < $signed(cfg_q[a]))
                     || ($signed(org[a]) > $signed(cfg_q[a+NUM_AXES]));

    always_ff @(posedge clk_i) begin
      if (adv) begin
        mag_lo_q[a] <= dlo[WORD_W] ? nlo[WORD_W-1:0] : dlo[WORD_W-1:0];
        mag_hi_q[a] <= dhi[WORD_W] ? nhi[WORD_W-1:0] : dhi[WORD_W-1:0];
        dmag_q[a]   <= dmag;
      end
    end
  end

  assign side_d.miss = |(side_d.par & outside);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side_d;
      for (int s = 1; s <= DivSt; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  // Divider stages, one unit per slab bound.
  logic [QuoW-1:0] quo_lo [NUM_AXES];
  logic [QuoW-1:0] quo_hi [NUM_AXES];

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_div
    rbfs_div #(.FRAC_BITS(FRAC_BITS)) u_div_lo (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (mag_lo_q[a]),
      .den_i (dmag_q[a]),
      .quo_o (quo_lo[a])
    );
    rbfs_div #(.FRAC_BITS(FRAC_BITS)) u_div_hi (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (mag_hi_q[a]),
      .den_i (dmag_q[a]),
      .quo_o (quo_hi[a])
    );
  end

  // Apply the sign and clamp to the signed 32-bit range.
  function automatic logic [WORD_W-1:0] sat_quo(logic [QuoW-1:0] q, logic neg);
    logic [WORD_W-1:0] r;
    r = '0;
    if (!neg) begin
      r = (|q[QuoW-1:WORD_W-1]) ? {1'b0, {(WORD_W-1){1'b1}}} : q[WORD_W-1:0];
    end else if ((|q[QuoW-1:WORD_W]) || (q[WORD_W-1] && (|q[WORD_W-2:0]))) begin
      r = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      r = -q[WORD_W-1:0];
    end
    return r;
  endfunction

  logic [WORD_W-1:0]   t_lo_q [NUM_AXES];
  logic [WORD_W-1:0]   t_hi_q [NUM_AXES];
  logic [NUM_AXES-1:0] par_sat_q, par_swp_q, par_fld_q;
  logic                miss_sat_q, miss_swp_q, miss_fld_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        t_lo_q[a] <= sat_quo(quo_lo[a], side_q[DivSt].neg_lo[a]);
        t_hi_q[a] <= sat_quo(quo_hi[a], side_q[DivSt].neg_hi[a]);
      end
      par_sat_q  <= side_q[DivSt].par;
      miss_sat_q <= side_q[DivSt].miss;
    end
  end

  // Order each slab pair so that the near parameter comes first.
  logic [WORD_W-1:0] tn_q [NUM_AXES];
  logic [WORD_W-1:0] tf_q [NUM_AXES];
  logic [FACE_W-1:0] fn_q [NUM_AXES];
  logic [FACE_W-1:0] ff_q [NUM_AXES];

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_swap
    logic swap;
    assign swap = $signed(t_lo_q[a]) > $signed(t_hi_q[a]);

    always_ff @(posedge clk_i) begin
      if (adv) begin
        tn_q[a] <= swap ? t_hi_q[a] : t_lo_q[a];
        tf_q[a] <= swap ? t_lo_q[a] : t_hi_q[a];
        fn_q[a] <= FACE_W'(2 * a + (swap ? 1 : 0));
        ff_q[a] <= FACE_W'(2 * a + (swap ? 0 : 1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      par_swp_q  <= par_sat_q;
      miss_swp_q <= miss_sat_q;
    end
  end

  // Fold the three axes into the entry maximum and exit minimum.
  logic [TW-1:0]     enter_d, leave_d, enter_q, leave_q;
  logic [FACE_W-1:0] ef_d, lf_d, ef_q, lf_q;
  logic              any_d, any_q;

  always_comb begin
    enter_d = {2'b10, {(WORD_W-1){1'b1}}};
    leave_d = {2'b01, {(WORD_W-1){1'b0}}};
    ef_d    = FACE_NONE;
    lf_d    = FACE_NONE;
    any_d   = 1'b0;
    for (int a = 0; a < NUM_AXES; a++) begin
      if (!par_swp_q[a]) begin
        any_d = 1'b1;
        if ($signed({tn_q[a][WORD_W-1], tn_q[a]}) > $signed(enter_d)) begin
          enter_d = {tn_q[a][WORD_W-1], tn_q[a]};
          ef_d    = fn_q[a];
        end
        if ($signed({tf_q[a][WORD_W-1], tf_q[a]}) < $signed(leave_d)) begin
          leave_d = {tf_q[a][WORD_W-1], tf_q[a]};
          lf_d    = ff_q[a];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      enter_q    <= enter_d;
      leave_q    <= leave_d;
      ef_q       <= ef_d;
      lf_q       <= lf_d;
      any_q      <= any_d;
      par_fld_q  <= par_swp_q;
      miss_fld_q <= miss_swp_q;
    end
  end

  // Final decision.
  res_t res_d;
  logic hit_d;

  assign hit_d = !miss_fld_q && any_q && !($signed(enter_q) > $signed(leave_q))
              && !leave_q[WORD_W] && (par_fld_q != '1);
  assign res_d.hit  = hit_d;
  assign res_d.face = !hit_d ? FACE_NONE : (enter_q[WORD_W] ? lf_q : ef_q);

  // Output register with one skid entry.
  res_t out_data_q, skid_data_q;
  logic pv, out_take;

  assign pv       = v_q[FldIdx] && adv;
  assign out_take = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_v_q    <= 1'b0;
    end else if (!out_valid_q || out_take) begin
      out_valid_q <= skid_v_q || pv;
      skid_v_q    <= 1'b0;
    end else if (pv) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_take) begin
      out_data_q <= skid_v_q ? skid_data_q : res_d;
    end else if (pv) begin
      skid_data_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_miss_face: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.hit |-> out_data_o.face == FACE_NONE)
    else $error("miss word carries a nonzero face");

  a_face_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.hit |-> out_data_o.face <= FACE_MAX)
    else $error("face index out of range");

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_valid_q)
    else $error("skid entry full while output register is empty");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && !out_stall_i |=> !skid_v_q)
    else $error("skid entry not drained when output was taken");

endmodule

// ===== verif/testbench.sv =====
// Testbench for the ray and box face select block: directed table plus random rays.
`timescale 1ns / 1ps

module testbench;
  import rbfs_pkg::*;

  localparam int LATENCY   = 29;
  localparam int WDOG_MAX  = 20000;
  localparam int RAND_RAYS = 1150;

  typedef struct {
    ray_t ray;
    logic known;
    res_t res;
  } ray_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = REG_LOW_X;
  logic [WORD_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  ray_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  res_t out_data_o;

  logic signed [WORD_W-1:0] box_reg [NUM_REGS];
  res_t hit_queue [$];
  int errors = 0;
  int idle_cycles = 0;
  bit stim_done = 1'b0;

  always #5 clk_i = ~clk_i;

  ray_box_face_select dut (.*);

  function automatic longint slab_t(longint bound, longint org, longint dir);
    longint q;
    q = ((bound - org) * (longint'(1) << FRAC_BITS_DEF)) / dir;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q;
  endfunction

  function automatic res_t trace_ray(ray_t r);
    longint enter, leave, org, dir, lo, hi, tn, tf, tt;
    int enter_face, leave_face, fn, ff, tfc, face;
    bit miss;
    res_t res;
    logic signed [WORD_W-1:0] o [NUM_AXES];
    logic signed [WORD_W-1:0] d [NUM_AXES];
    o = '{r.origin_x, r.origin_y, r.origin_z};
    d = '{r.dir_x, r.dir_y, r.dir_z};
    enter = -64'sd2147483649;
    leave = 64'sd2147483648;
    enter_face = -1;
    leave_face = -1;
    miss = 1'b0;
    face = -1;
    for (int a = 0; a < NUM_AXES; a++) begin
      org = o[a];
      dir = d[a];
      lo = box_reg[a];
      hi = box_reg[a+3];
      if ((dir < 0 ? -dir : dir) < PARALLEL_EPS_DEF) begin
        if (org < lo || org > hi) miss = 1'b1;
        continue;
      end
      tn = slab_t(lo, org, dir);
      tf = slab_t(hi, org, dir);
      fn = a * 2;
      ff = a * 2 + 1;
      if (tn > tf) begin
        tt = tn; tn = tf; tf = tt;
        tfc = fn; fn = ff; ff = tfc;
      end
      if (tn > enter) begin
        enter = tn;
        enter_face = fn;
      end
      if (tf < leave) begin
        leave = tf;
        leave_face = ff;
      end
    end
    if (!miss && !(enter > leave || leave < 0))
      face = enter >= 0 ? enter_face : leave_face;
    res.hit = face >= 0;
    res.face = face >= 0 ? FACE_W'(face) : FACE_NONE;
    return res;
  endfunction

  task automatic write_box(cfg_reg_e idx, logic [WORD_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    box_reg[idx] = val;
  endtask

  task automatic set_box(logic [WORD_W-1:0] lx, ly, lz, hx, hy, hz);
    write_box(REG_LOW_X, lx);
    write_box(REG_LOW_Y, ly);
    write_box(REG_LOW_Z, lz);
    write_box(REG_HIGH_X, hx);
    write_box(REG_HIGH_Y, hy);
    write_box(REG_HIGH_Z, hz);
  endtask

  task automatic drain;
    while (hit_queue.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  // Holds the ray on the bus until the block takes it; gaps come before it.
  task automatic send_ray(ray_t r, logic known, res_t res);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (known) hit_queue.push_back(res);
    else hit_queue.push_back(trace_ray(r));
  endtask

  function automatic logic [WORD_W-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      2: return '0;
      3: return $urandom_range(0, 1) ? 32'h0000_0001 : 32'hffff_ffff;
      default: return 32'($signed($urandom_range(0, 6 << 16)) - (2 << 16));
    endcase
  endfunction

  function automatic ray_t rand_ray();
    ray_t r;
    r.origin_x = rand_coord();
    r.origin_y = rand_coord();
    r.origin_z = rand_coord();
    r.dir_x = rand_coord();
    r.dir_y = rand_coord();
    r.dir_z = rand_coord();
    return r;
  endfunction

  // A ray aimed from a random origin at a point inside the box, so many rays hit.
  function automatic ray_t aimed_ray();
    ray_t r;
    logic signed [WORD_W-1:0] o [NUM_AXES];
    logic signed [WORD_W-1:0] d [NUM_AXES];
    longint lo, hi, tgt;
    for (int a = 0; a < NUM_AXES; a++) begin
      lo = box_reg[a];
      hi = box_reg[a+3];
      tgt = (hi > lo) ? lo + longint'($urandom()) % (hi - lo + 1) : lo;
      o[a] = 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      d[a] = 32'(tgt - longint'(o[a]));
      if ($urandom_range(0, 15) == 0) d[a] = '0;
    end
    r.origin_x = o[0]; r.origin_y = o[1]; r.origin_z = o[2];
    r.dir_x = d[0]; r.dir_y = d[1]; r.dir_z = d[2];
    return r;
  endfunction

  initial begin
    ray_row_t rows [$];
    ray_row_t row;
    box_reg = '{BOX_LOW_RST, BOX_LOW_RST, BOX_LOW_RST,
                BOX_HIGH_RST, BOX_HIGH_RST, BOX_HIGH_RST};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rays against the reset unit box.
    row.known = 1'b1;
    row.ray = '{32'hffff_0000, 32'h0000_8000, 32'h0000_8000, 32'h0001_0000, 0, 0};
    row.res = '{1'b1, 3'd0};
    rows.push_back(row);
    row.ray = '{32'h0002_0000, 32'h0000_8000, 32'h0000_8000, 32'hffff_0000, 0, 0};
    row.res = '{1'b1, 3'd1};
    rows.push_back(row);
    row.ray = '{32'h0000_8000, 32'hffff_0000, 32'h0000_8000, 0, 32'h0001_0000, 0};
    row.res = '{1'b1, 3'd2};
    rows.push_back(row);
    row.ray = '{32'h0000_8000, 32'h0000_8000, 32'h0002_0000, 0, 0, 32'hffff_0000};
    row.res = '{1'b1, 3'd5};
    rows.push_back(row);
    // Origin inside: exit face.
    row.ray = '{32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 0, 32'h0001_0000, 0};
    row.res = '{1'b1, 3'd3};
    rows.push_back(row);
    // Parallel axis outside its slab.
    row.ray = '{32'h0003_0000, 32'h0000_8000, 32'hffff_0000, 0, 0, 32'h0001_0000};
    row.res = '{1'b0, FACE_NONE};
    rows.push_back(row);
    // All axes parallel with the origin inside.
    row.ray = '{32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 0, 0, 0};
    row.res = '{1'b0, FACE_NONE};
    rows.push_back(row);
    // Box behind the ray.
    row.ray = '{32'h0002_0000, 32'h0000_8000, 32'h0000_8000, 32'h0001_0000, 0, 0};
    row.res = '{1'b0, FACE_NONE};
    rows.push_back(row);
    row.known = 1'b0;
    row.ray = '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001};
    rows.push_back(row);
    row.ray = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff};
    rows.push_back(row);
    row.ray = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                32'h0000_0001, 32'h0000_0001, 32'h0000_0001};
    rows.push_back(row);
    row.ray = '{0, 0, 0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff};
    rows.push_back(row);
    foreach (rows[i]) send_ray(rows[i].ray, rows[i].known, rows[i].res);
    in_valid_i <= 1'b0;
    drain();

    // Random phases over several boxes, extremes and an inverted one included.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: ;
        1: set_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        2: set_box(32'h0001_0000, 32'h0000_8000, 32'h0000_0000,
                   32'h0000_0000, 32'h0000_0000, 32'h0000_8000);
        3: set_box(32'hfffe_0000, 32'hffff_8000, 32'hffff_0000,
                   32'h0002_0000, 32'h0000_8000, 32'h0003_0000);
        4: set_box(32'hffff_ffff, 32'h0000_0000, 32'h7fff_fff0,
                   32'h0000_0001, 32'h0000_0000, 32'h7fff_ffff);
        default: set_box($urandom(), $urandom(), $urandom(),
                         $urandom(), $urandom(), $urandom());
      endcase
      for (int k = 0; k < RAND_RAYS / 6; k++)
        send_ray(($urandom_range(0, 2) != 0) ? aimed_ray() : rand_ray(), 1'b0, '0);
      in_valid_i <= 1'b0;
      drain();
    end
    stim_done = 1'b1;
  end

  // Output stall pattern: mostly short, a few long, some free-running stretches.
  always @(posedge clk_i) begin
    if ($urandom_range(0, 99) < 30) out_stall_i <= ($urandom_range(0, 20) == 0) ? 1'b1
                                                  : 1'($urandom_range(0, 1));
    else if ($urandom_range(0, 9) == 0) out_stall_i <= 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (hit_queue.size() == 0) begin
        $error("unexpected word: hit=%0b face=%0d", out_data_o.hit, out_data_o.face);
        errors++;
      end else begin
        res_t want;
        want = hit_queue.pop_front();
        if (out_data_o.hit !== want.hit) begin
          $error("hit: expected %0b, got %0b", want.hit, out_data_o.hit);
          errors++;
        end
        if (out_data_o.face !== want.face) begin
          $error("face: expected %0d, got %0d", want.face, out_data_o.face);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (stim_done || idle_cycles >= WDOG_MAX);
    if (!stim_done) begin
      $display("end of test: mismatches");
    end else begin
      if (errors == 0 && hit_queue.size() == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/rbfs_pkg.sv
rtl/core/rbfs_div.sv
rtl/core/ray_box_face_select.sv
verif/testbench.sv
